FILE: sv/rgtt_pkg.sv
// Shared constants and types for the range-gated track table.
`timescale 1ns / 1ps
package rgtt_pkg;
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W = 16 + IDX_W + 1;

   localparam logic [1:0] REG_SENSE = 2'd0;
   localparam logic [1:0] REG_STALL_EN = 2'd1;
   localparam logic [1:0] REG_STALL_DIST = 2'd2;
   localparam logic [1:0] REG_CRUISE = 2'd3;

   typedef struct packed {
      logic [14:0] sense_range;
      logic        stall_enable;
      logic [14:0] stall_distance;
      logic [15:0] cruise_speed;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic neg;
      logic [SUM_W-1:0] num;
      logic [CNT_W-1:0] den;
   } div_req_type;
endpackage

FILE: sv/rgtt_dist.sv
// Squared-distance unit: one 17x17 multiply per cycle, registered.
`timescale 1ns / 1ps
module rgtt_dist (
   input  logic        clock,
   input  logic [16:0] a_mag,
   output logic [33:0] sq_ff
);
   logic [33:0] sq_in;
   assign sq_in = a_mag * a_mag;
   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end
endmodule

FILE: sv/rgtt_div.sv
// Restoring divider, one quotient bit per cycle, truncates toward zero.
`timescale 1ns / 1ps
module rgtt_div (
   input  logic                     clock,
   input  logic                     reset,
   input  rgtt_pkg::div_req_type    req,
   output logic                     busy,
   output logic [15:0]              quot
);
   localparam int W = rgtt_pkg::SUM_W;
   localparam int CW = rgtt_pkg::CNT_W;
   logic [W-1:0] q_ff, q_in;
   logic [W:0]   r_ff, r_in;
   logic [CW-1:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [$clog2(W+1)-1:0] n_ff, n_in;
   logic [W:0] trial;
   logic [W-1:0] qs;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff; n_in = n_ff;
      trial = {r_ff[W-1:0], q_ff[W-1]};
      if (req.start) begin
         q_in = req.num; r_in = '0; d_in = req.den; neg_in = req.neg;
         n_in = ($clog2(W+1))'(W);
      end else if (n_ff != '0) begin
         if (trial >= {{(W+1-CW){1'b0}}, d_ff}) begin
            r_in = trial - {{(W+1-CW){1'b0}}, d_ff};
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[W-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign qs = neg_ff ? (~q_ff + 1'b1) : q_ff;
   assign quot = qs[15:0];
   assign busy = (n_ff != '0);
endmodule

FILE: sv/range_gated_track_table_centroid_unit.sv
// Top level: track table, sequencer, shared distance multiplier and divider.
// Observation: range gate (S_DX, S_DY, S_GATE), ID search over the table (S_SRD, S_SCMP), then S_WRITE.
// End of scan then walks the table for the stall check and sums (S_WRD, S_WX, S_WY, S_WCMP), runs
// the two divides and posts the result in S_OUT; rsp_tvalid is high the cycle after.
// Throughput: one transaction at a time; req_tready is high only in idle. A waiting result does
// not block input; only the next end of scan waits for it. Single multiplier and table port.
// Reset (synchronous, active high) empties the table, clears the drop flag, loads register defaults.
`timescale 1ns / 1ps
module range_gated_track_table_centroid_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: tracker_x[15:0], tracker_y[31:16], target_id[41:32], target_x[57:42],
   // target_y[73:58], zero pad [79:74]
   input  logic [79:0] req_tdata,
   input  logic        req_tlast,   // end_of_scan
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: centroid_x[15:0], centroid_y[31:16], centroid_valid[32], tracked_count[39:33],
   // stalled[40], speed[56:41], dropped[57], zero pad [63:58]
   output logic [63:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int D = rgtt_pkg::TABLE_DEPTH;
   localparam int IW = rgtt_pkg::IDX_W;
   localparam int CW = rgtt_pkg::CNT_W;
   localparam int SW = rgtt_pkg::SUM_W;

   localparam logic [3:0] S_IDLE = 4'd0, S_DX = 4'd1, S_DY = 4'd2, S_GATE = 4'd3,
      S_SRD = 4'd4, S_SCMP = 4'd5, S_WRITE = 4'd6, S_WRD = 4'd7, S_WX = 4'd8,
      S_WY = 4'd9, S_WCMP = 4'd10, S_DIVX = 4'd11, S_DIVY = 4'd12, S_OUT = 4'd13,
      S_DIVXW = 4'd14, S_DIVYW = 4'd15;

   rgtt_pkg::cfg_type cfg_ff;
   logic [3:0] st_ff, st_in;
   logic signed [15:0] tx_ff, ty_ff, gx_ff, gy_ff, ex_ff, ey_ff;
   logic [9:0] id_ff, eid_ff;
   logic last_ff;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in;
   logic drop_ff, drop_in, found_ff, found_in, close_ff, close_in;
   logic [34:0] acc_ff, acc_in;
   logic signed [SW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [15:0] cx_ff, cx_in;
   logic [63:0] out_ff, out_in;
   logic ov_ff, ov_in;

   logic [9:0]  mem_id [D];
   logic [15:0] mem_x [D];
   logic [15:0] mem_y [D];
   logic we;
   logic [IW-1:0] waddr, raddr;

   logic [16:0] mag;
   logic signed [16:0] diff;
   logic [33:0] sq;
   rgtt_pkg::div_req_type dreq;
   logic dbusy;
   logic [15:0] dq;
   logic [29:0] rr, ss;
   logic stall_now;

   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         rgtt_pkg::REG_SENSE:      csr_prdata = {17'd0, cfg_ff.sense_range};
         rgtt_pkg::REG_STALL_EN:   csr_prdata = {31'd0, cfg_ff.stall_enable};
         rgtt_pkg::REG_STALL_DIST: csr_prdata = {17'd0, cfg_ff.stall_distance};
         default:                  csr_prdata = {16'd0, cfg_ff.cruise_speed};
      endcase
   end

   logic cfg_wr;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sense_range <= 15'd1600;
         cfg_ff.stall_enable <= 1'b0;
         cfg_ff.stall_distance <= 15'd48;
         cfg_ff.cruise_speed <= 16'd16;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            rgtt_pkg::REG_SENSE:      cfg_ff.sense_range <= csr_pwdata[14:0];
            rgtt_pkg::REG_STALL_EN:   cfg_ff.stall_enable <= csr_pwdata[0];
            rgtt_pkg::REG_STALL_DIST: cfg_ff.stall_distance <= csr_pwdata[14:0];
            default:                  cfg_ff.cruise_speed <= csr_pwdata[15:0];
         endcase
      end
   end

   // squares of the radii, constant while busy only if the user writes no register then; not enforced here
   assign rr = cfg_ff.sense_range * cfg_ff.sense_range;
   assign ss = cfg_ff.stall_distance * cfg_ff.stall_distance;

   always_comb begin
      case (st_ff)
         S_DX, S_WX: diff = (st_ff == S_DX) ? (17'(tx_ff) - 17'(gx_ff)) : (17'(tx_ff) - 17'(ex_ff));
         default:    diff = (st_ff == S_DY) ? (17'(ty_ff) - 17'(gy_ff)) : (17'(ty_ff) - 17'(ey_ff));
      endcase
      mag = diff[16] ? (~diff + 1'b1) : diff;
   end

   rgtt_dist u_dist (.clock(clock), .a_mag(mag), .sq_ff(sq));
   rgtt_div u_div (.clock(clock), .reset(reset), .req(dreq), .busy(dbusy), .quot(dq));

   assign raddr = i_ff[IW-1:0];
   always_ff @(posedge clock) begin
      if (we) begin
         mem_id[waddr] <= id_ff;
         mem_x[waddr] <= gx_ff;
         mem_y[waddr] <= gy_ff;
      end
      eid_ff <= mem_id[raddr];
      ex_ff <= mem_x[raddr];
      ey_ff <= mem_y[raddr];
   end

   assign req_tready = (st_ff == S_IDLE);
   assign stall_now = close_ff && cfg_ff.stall_enable;

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; i_in = i_ff; drop_in = drop_ff;
      found_in = found_ff; close_in = close_ff; acc_in = acc_ff;
      sx_in = sx_ff; sy_in = sy_ff; cx_in = cx_ff; out_in = out_ff; ov_in = ov_ff;
      we = 1'b0; waddr = i_ff[IW-1:0];
      dreq = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: if (req_tvalid && req_tready) st_in = S_DX;
         S_DX: st_in = S_DY;
         S_DY: begin
            acc_in = 35'(sq);
            st_in = S_GATE;
         end
         S_GATE: begin
            i_in = '0;
            found_in = 1'b0;
            if (acc_ff + 35'(sq) <= 35'(rr)) st_in = (cnt_ff == '0) ? S_WRITE : S_SRD;
            else st_in = last_ff ? S_WRD : S_IDLE;
         end
         S_SRD: st_in = S_SCMP;
         S_SCMP: begin
            if (eid_ff == id_ff) begin
               found_in = 1'b1;
               st_in = S_WRITE;
            end else if (i_ff + 1'b1 == cnt_ff) begin
               i_in = cnt_ff;
               st_in = S_WRITE;
            end else begin
               i_in = i_ff + 1'b1;
               st_in = S_SRD;
            end
         end
         S_WRITE: begin
            if (found_ff) begin
               we = 1'b1;
            end else if (cnt_ff < CW'(D)) begin
               waddr = cnt_ff[IW-1:0];
               we = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               drop_in = 1'b1;
            end
            st_in = last_ff ? S_WRD : S_IDLE;
            i_in = '0;
         end
         S_WRD: begin
            i_in = '0; close_in = 1'b0; sx_in = '0; sy_in = '0;
            st_in = (cnt_ff == '0) ? S_DIVX : S_WX;
         end
         S_WX: st_in = S_WY;
         S_WY: begin
            acc_in = 35'(sq);
            i_in = i_ff + 1'b1;
            st_in = S_WCMP;
         end
         S_WCMP: begin
            if (acc_ff + 35'(sq) < 35'(ss)) close_in = 1'b1;
            sx_in = sx_ff + SW'(ex_ff);
            sy_in = sy_ff + SW'(ey_ff);
            st_in = (i_ff == cnt_ff) ? S_DIVX : S_WX;
         end
         S_DIVX: begin
            dreq.start = 1'b1;
            dreq.neg = sx_ff[SW-1];
            dreq.num = sx_ff[SW-1] ? SW'(-sx_ff) : SW'(sx_ff);
            dreq.den = (cnt_ff == '0) ? CW'(1) : cnt_ff;
            st_in = S_DIVXW;
         end
         S_DIVXW: if (!dbusy) begin
            cx_in = dq;
            st_in = S_DIVY;
         end
         S_DIVY: begin
            dreq.start = 1'b1;
            dreq.neg = sy_ff[SW-1];
            dreq.num = sy_ff[SW-1] ? SW'(-sy_ff) : SW'(sy_ff);
            dreq.den = (cnt_ff == '0) ? CW'(1) : cnt_ff;
            st_in = S_DIVYW;
         end
         S_DIVYW: if (!dbusy) st_in = S_OUT;
         S_OUT: if (!ov_ff) begin
            out_in = {6'd0, drop_ff, stall_now ? 16'd0 : cfg_ff.cruise_speed, stall_now,
                      7'(cnt_ff), (cnt_ff != '0), dq, cx_ff};
            ov_in = 1'b1;
            drop_in = 1'b0;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // walk: entry i is read while i_ff holds i; i_ff steps at the end of S_WY, so the
   // registered read still shows entry i in S_WCMP and entry i+1 by the next S_WX
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; drop_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; drop_ff <= drop_in; ov_ff <= ov_in;
      end
      i_ff <= i_in; found_ff <= found_in; close_ff <= close_in; acc_ff <= acc_in;
      sx_ff <= sx_in; sy_ff <= sy_in; cx_ff <= cx_in; out_ff <= out_in;
      if (req_tvalid && req_tready) begin
         tx_ff <= req_tdata[15:0]; ty_ff <= req_tdata[31:16]; id_ff <= req_tdata[41:32];
         gx_ff <= req_tdata[57:42]; gy_ff <= req_tdata[73:58]; last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = out_ff;

   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(D))
      else $error("table count above depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |-> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("count moved by more than one");
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the range-gated track table centroid unit.
`timescale 1ns / 1ps
module tb;
   localparam int RAND_ITEMS = 1650;
   localparam int DRAIN_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic signed [15:0] trk_x;
      logic signed [15:0] trk_y;
      logic [9:0]         tgt_id;
      logic signed [15:0] tgt_x;
      logic signed [15:0] tgt_y;
      logic               scan_end;
   } sighting_type;

   typedef struct {
      logic signed [15:0] cen_x;
      logic signed [15:0] cen_y;
      logic               cen_ok;
      logic [6:0]         count;
      logic               stall;
      logic [15:0]        spd;
      logic               drop;
   } summary_type;

   class track_scoreboard;
      logic [14:0] sense_range = 15'd1600;
      logic        stall_en = 1'b0;
      logic [14:0] stall_dist = 15'd48;
      logic [15:0] cruise = 16'd16;
      logic [9:0]         ids[rgtt_pkg::TABLE_DEPTH];
      logic signed [15:0] xs[rgtt_pkg::TABLE_DEPTH];
      logic signed [15:0] ys[rgtt_pkg::TABLE_DEPTH];
      int          n_entries = 0;
      bit          drop_flag = 0;
      summary_type expected_q[$];
      int          errors = 0;

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            rgtt_pkg::REG_SENSE:      sense_range = val[14:0];
            rgtt_pkg::REG_STALL_EN:   stall_en = val[0];
            rgtt_pkg::REG_STALL_DIST: stall_dist = val[14:0];
            rgtt_pkg::REG_CRUISE:     cruise = val[15:0];
            default: ;
         endcase
      endfunction

      function longint dsq(longint ax, longint ay, longint bx, longint by);
         return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
      endfunction

      function void note_sighting(sighting_type s);
         longint sum_x, sum_y;
         bit found, near;
         summary_type r;
         sum_x = 0;
         sum_y = 0;
         found = 0;
         near = 0;
         if (dsq(s.trk_x, s.trk_y, s.tgt_x, s.tgt_y) <= longint'(sense_range) * sense_range) begin
            for (int i = 0; i < n_entries; i++)
               if (!found && ids[i] == s.tgt_id) begin
                  xs[i] = s.tgt_x;
                  ys[i] = s.tgt_y;
                  found = 1;
               end
            if (!found) begin
               if (n_entries < rgtt_pkg::TABLE_DEPTH) begin
                  ids[n_entries] = s.tgt_id;
                  xs[n_entries] = s.tgt_x;
                  ys[n_entries] = s.tgt_y;
                  n_entries++;
               end else begin
                  drop_flag = 1;
               end
            end
         end
         if (!s.scan_end) return;
         for (int i = 0; i < n_entries; i++) begin
            sum_x += xs[i];
            sum_y += ys[i];
            if (dsq(s.trk_x, s.trk_y, xs[i], ys[i]) < longint'(stall_dist) * stall_dist)
               near = 1;
         end
         near = near && stall_en;
         // integer division truncates toward zero
         r.cen_x = n_entries > 0 ? 16'(sum_x / n_entries) : 16'sd0;
         r.cen_y = n_entries > 0 ? 16'(sum_y / n_entries) : 16'sd0;
         r.cen_ok = n_entries > 0;
         r.count = 7'(n_entries);
         r.stall = near;
         r.spd = near ? 16'd0 : cruise;
         r.drop = drop_flag;
         drop_flag = 0;
         expected_q = {expected_q, r};
      endfunction

      function void check_summary(logic [63:0] d);
         summary_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction %h", d);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (d[15:0] !== e.cen_x) begin
            $error("centroid_x exp %0d got %0d", e.cen_x, $signed(d[15:0])); errors++;
         end
         if (d[31:16] !== e.cen_y) begin
            $error("centroid_y exp %0d got %0d", e.cen_y, $signed(d[31:16])); errors++;
         end
         if (d[32] !== e.cen_ok) begin
            $error("centroid_valid exp %0d got %0d", e.cen_ok, d[32]); errors++;
         end
         if (d[39:33] !== e.count) begin
            $error("tracked_count exp %0d got %0d", e.count, d[39:33]); errors++;
         end
         if (d[40] !== e.stall) begin
            $error("stalled exp %0d got %0d", e.stall, d[40]); errors++;
         end
         if (d[56:41] !== e.spd) begin
            $error("speed exp %0d got %0d", e.spd, d[56:41]); errors++;
         end
         if (d[57] !== e.drop) begin
            $error("dropped exp %0d got %0d", e.drop, d[57]); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;  // tracker_x, tracker_y, target_id, target_x, target_y, pad
   logic        req_tlast = 0;   // end_of_scan
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;       // centroid_x, centroid_y, centroid_valid, tracked_count,
                                 // stalled, speed, dropped, pad
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   track_scoreboard sb = new();
   bit     calm = 0;     // no idling on either side
   int     rx_hold = 0;
   longint cycles = 0;

   range_gated_track_table_centroid_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // receiver side: random stall bursts
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold <= rx_hold - 1;
      end else if ($urandom_range(3) == 0) begin
         rsp_tready <= 1'b0;
         rx_hold <= $urandom_range(11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sighting_type s;
      if (!reset && req_tvalid && req_tready) begin
         s.trk_x = req_tdata[15:0];
         s.trk_y = req_tdata[31:16];
         s.tgt_id = req_tdata[41:32];
         s.tgt_x = req_tdata[57:42];
         s.tgt_y = req_tdata[73:58];
         s.scan_end = req_tlast;
         sb.note_sighting(s);
      end
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_summary(rsp_tdata);
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic setup_regs(logic [14:0] rng, logic en, logic [14:0] sdist, logic [15:0] spd);
      csr_write(rgtt_pkg::REG_SENSE, 32'(rng));
      csr_write(rgtt_pkg::REG_STALL_EN, 32'(en));
      csr_write(rgtt_pkg::REG_STALL_DIST, 32'(sdist));
      csr_write(rgtt_pkg::REG_CRUISE, 32'(spd));
   endtask

   task automatic send_sighting(logic [15:0] tkx, logic [15:0] tky, logic [9:0] id,
                                logic [15:0] gx, logic [15:0] gy, logic last);
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, gy, gx, id, tky, tkx};
      req_tlast <= last;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      if (!calm && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
   endtask

   // let every result drain, then give the block time to settle
   task automatic wait_idle();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [15:0] tkx, tky, gx, gy;
      logic [9:0]  id;
      int          len, sent;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, then far target out of range at the field extremes
      send_sighting(16'h8000, 16'h8000, 10'd5, 16'h7fff, 16'h7fff, 1'b1);
      send_sighting(16'h8000, 16'h8000, 10'd0, 16'h8000, 16'h8000, 1'b0);
      send_sighting(16'h7fff, 16'h7fff, 10'd1023, 16'h7fff, 16'h7fff, 1'b1);
      send_sighting(16'h0000, 16'h0000, 10'd0, 16'hffff, 16'h0001, 1'b0);  // update id 0
      send_sighting(16'h0000, 16'h0000, 10'd341, 16'hfff0, 16'hffc3, 1'b1);
      wait_idle();

      // zero range: only an exact hit counts; stall everywhere
      setup_regs(15'd0, 1'b1, 15'h7fff, 16'hffff);
      send_sighting(16'h0123, 16'hfedc, 10'd682, 16'h0123, 16'hfedc, 1'b0);
      send_sighting(16'h0123, 16'hfedc, 10'd7, 16'h0124, 16'hfedc, 1'b1);
      wait_idle();
      setup_regs(15'h7fff, 1'b1, 15'd0, 16'd0);
      send_sighting(16'h4000, 16'hc000, 10'd8, 16'hc000, 16'h4000, 1'b1);
      send_sighting(16'h0000, 16'h0000, 10'd9, 16'h5555, 16'haaaa, 1'b1);
      wait_idle();

      sent = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: setup_regs(15'd1600, 1'b0, 15'd48, 16'd16);
            1: setup_regs(15'h7fff, 1'b1, 15'd3000, 16'd0);
            2: setup_regs(15'($urandom), 1'b1, 15'($urandom_range(4000)), 16'($urandom));
            3: setup_regs(15'd0, 1'b1, 15'h7fff, 16'hffff);
            4: setup_regs(15'd2500, 1'b1, 15'd0, 16'($urandom));
            default: setup_regs(15'($urandom_range(8000)), 1'b1, 15'($urandom_range(3000)),
                                16'($urandom));
         endcase
         for (int k = 0; k < RAND_ITEMS / 6; ) begin
            len = $urandom_range(12, 1);
            tkx = 16'($urandom);
            tky = 16'($urandom);
            for (int j = 0; j < len; j++, k++) begin
               sent++;
               calm = sent > RAND_ITEMS - 150;
               id = ($urandom_range(9) < 7) ? 10'($urandom_range(79)) : 10'($urandom);
               if ($urandom_range(3) != 0) begin
                  gx = tkx + 16'($signed($urandom_range(4000)) - 2000);
                  gy = tky + 16'($signed($urandom_range(4000)) - 2000);
               end else begin
                  gx = 16'($urandom);
                  gy = 16'($urandom);
               end
               if (phase == 3 && $urandom_range(1) == 0) begin
                  gx = tkx;
                  gy = tky;
               end
               send_sighting(tkx, tky, id, gx, gy, j == len - 1);
            end
         end
         wait_idle();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule
